// ----- rtl/core/sha1bh_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 block hash package
// Shared word types, initial hash values, round constants and round logic.
// ----------------------------------------------------------------------------
package sha1bh_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int ROUND_W     = 7;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;

  // Packed so that H_INIT[0] is H0.
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_CHOOSE = 32'h5A827999;
  localparam logic [31:0] K_PAR1   = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2   = 32'hCA62C1D6;

  typedef struct packed {
    logic [31:0] msg_word;
    logic        end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_word_t;

  // What the front hands to the back for each accepted word.
  typedef struct packed {
    logic [31:0] word;
    logic        blk_done;
    logic        eom;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_DIGEST
  } core_state_t;

  typedef struct packed {
    core_state_t        state;
    logic [ROUND_W-1:0] round;
  } core_status_t;

  function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K_CHOOSE;
    end else if (t < 7'd40) begin
      k = K_PAR1;
    end else if (t < 7'd60) begin
      k = K_MAJ;
    end else begin
      k = K_PAR2;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [ROUND_W-1:0] t,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ----- rtl/core/sha1_block_hash_top.sv -----
// A block finishes after its sixteenth word leaves the queue (the load step,
// 80 rounds in the single round unit, one chain add); at end of message digest
// words follow at one per cycle while out_stall is low. The engine takes no
// further word from the queue until a block is done; a digest is five words.
// Reset (synchronous, active low) empties the queue, clears the word count and
// loads the SHA-1 initial hash values into the chaining words.
// ----------------------------------------------------------------------------
// SHA-1 block hash top level
// Front end, word queue and round engine for padded 32-bit message words.
// ----------------------------------------------------------------------------
module sha1_block_hash_top #(
  parameter int QUEUE_DEPTH = sha1bh_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha1bh_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1bh_pkg::out_word_t out_data
);

  logic                             q_push;
  logic                             q_pop;
  logic                             q_empty;
  logic                             q_full;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
  sha1bh_pkg::tag_t                 push_tag;
  sha1bh_pkg::tag_t                 pop_tag;
  sha1bh_pkg::core_status_t         status;

  sha1bh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push),
    .push_tag (push_tag)
  );

  sha1bh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tag (push_tag),
    .pop      (q_pop),
    .pop_tag  (pop_tag),
    .empty    (q_empty),
    .full     (q_full),
    .level    (q_level)
  );

  sha1bh_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop_tag   (pop_tag),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("word queue level exceeds its depth");

  a_round_range : assert property (@(posedge clk) disable iff (!rst_n)
    (status.state == sha1bh_pkg::ST_ROUND) |-> (status.round <= sha1bh_pkg::LAST_ROUND))
    else $error("round counter out of range");

  a_add_after_rounds : assert property (@(posedge clk) disable iff (!rst_n)
    (status.state == sha1bh_pkg::ST_ADD) |->
      ($past(status.state) == sha1bh_pkg::ST_ROUND &&
       $past(status.round) == sha1bh_pkg::LAST_ROUND))
    else $error("chain add entered without a full set of rounds");

  a_pop_only_idle : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (status.state == sha1bh_pkg::ST_IDLE && !q_empty))
    else $error("queue popped outside idle or while empty");

  a_last_spacing : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.digest_last) |=>
      !(out_valid && out_data.digest_last))
    else $error("digest end marker repeated");

endmodule

// ----- rtl/core/sha1bh_front.sv -----
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts message words, counts them within the block and tags each one.
// ----------------------------------------------------------------------------
module sha1bh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha1bh_pkg::in_word_t in_data,
  input  logic               q_full,
  output logic               push,
  output sha1bh_pkg::tag_t   push_tag
);

  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign push_tag.word     = in_data.msg_word;
  assign push_tag.blk_done = (cnt_r == 4'd15);
  assign push_tag.eom      = in_data.end_of_message;

  // An end flag always starts a fresh block, even in the middle of one.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = in_data.end_of_message ? 4'd0 : cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/sha1bh_queue.sv -----
// ----------------------------------------------------------------------------
// SHA-1 word queue
// Small FIFO of tagged words between the front end and the round engine.
// ----------------------------------------------------------------------------
module sha1bh_queue #(
  parameter int DEPTH = sha1bh_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  sha1bh_pkg::tag_t           push_tag,
  input  logic                       pop,
  output sha1bh_pkg::tag_t           pop_tag,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);
  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

  sha1bh_pkg::tag_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [LVL_W-1:0] level_r;

  assign empty   = (level_r == '0);
  assign full    = (level_r == LVL_FULL);
  assign level   = level_r;
  assign pop_tag = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
      end
      if (push && !pop) begin
        level_r <= level_r + LVL_ONE;
      end else if (pop && !push) begin
        level_r <= level_r - LVL_ONE;
      end
    end
  end

endmodule

// ----- rtl/core/sha1bh_core.sv -----
// ----------------------------------------------------------------------------
// SHA-1 round engine
// Loads the message schedule, runs 80 rounds, updates the digest and emits it at end of message.
// ----------------------------------------------------------------------------
module sha1bh_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  sha1bh_pkg::tag_t         pop_tag,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sha1bh_pkg::out_word_t    out_data,
  output sha1bh_pkg::core_status_t status
);

  sha1bh_pkg::core_state_t state_r, state_nxt;
  logic [sha1bh_pkg::ROUND_W-1:0] round_r, round_nxt;
  logic [2:0]  dig_r, dig_nxt;
  logic        eom_r, eom_nxt;
  logic        out_valid_r, out_valid_nxt;
  sha1bh_pkg::out_word_t out_data_r, out_data_nxt;

  logic [31:0] win_r   [16];
  logic [31:0] win_nxt [16];
  logic [31:0] work_r   [5];
  logic [31:0] work_nxt [5];
  logic [31:0] chain_r   [5];
  logic [31:0] chain_nxt [5];

  logic [31:0] sched_word;
  logic [31:0] sched_mix;
  logic [31:0] round_sum;
  logic        out_free;

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign status.state  = state_r;
  assign status.round  = round_r;

  assign out_free = !out_valid_r || !out_stall;

  // During the rounds the window holds W[t] .. W[t+15], so round t reads the bottom tap
  // and pushes W[t+16] on top.
  assign sched_mix  = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign sched_word = {sched_mix[30:0], sched_mix[31]};
  assign round_sum  = {work_r[0][26:0], work_r[0][31:27]}
                    + sha1bh_pkg::round_f(round_r, work_r[1], work_r[2], work_r[3])
                    + work_r[4] + win_r[0] + sha1bh_pkg::round_k(round_r);

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    dig_nxt       = dig_r;
    eom_nxt       = eom_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    for (int i = 0; i < 16; i++) begin
      win_nxt[i] = win_r[i];
    end
    for (int i = 0; i < 5; i++) begin
      work_nxt[i]  = work_r[i];
      chain_nxt[i] = chain_r[i];
    end

    unique case (state_r)
      sha1bh_pkg::ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          for (int i = 0; i < 15; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[15] = pop_tag.word;
          if (pop_tag.blk_done) begin
            for (int i = 0; i < 5; i++) begin
              work_nxt[i] = chain_r[i];
            end
            round_nxt = '0;
            eom_nxt   = pop_tag.eom;
            state_nxt = sha1bh_pkg::ST_ROUND;
          end else if (pop_tag.eom) begin
            // Partial block is dropped; the current chain goes out as is.
            dig_nxt   = 3'd0;
            state_nxt = sha1bh_pkg::ST_DIGEST;
          end
        end
      end
      sha1bh_pkg::ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[15] = sched_word;
        work_nxt[0] = round_sum;
        work_nxt[1] = work_r[0];
        work_nxt[2] = {work_r[1][1:0], work_r[1][31:2]};
        work_nxt[3] = work_r[2];
        work_nxt[4] = work_r[3];
        round_nxt   = round_r + 7'd1;
        if (round_r == sha1bh_pkg::LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = sha1bh_pkg::ST_ADD;
        end
      end
      sha1bh_pkg::ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        dig_nxt   = 3'd0;
        state_nxt = eom_r ? sha1bh_pkg::ST_DIGEST : sha1bh_pkg::ST_IDLE;
      end
      sha1bh_pkg::ST_DIGEST: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = chain_r[dig_r];
          out_data_nxt.digest_last = (dig_r == 3'd4);
          if (dig_r == 3'd4) begin
            for (int i = 0; i < 5; i++) begin
              chain_nxt[i] = sha1bh_pkg::H_INIT[i];
            end
            state_nxt = sha1bh_pkg::ST_IDLE;
          end else begin
            dig_nxt = dig_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = sha1bh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1bh_pkg::ST_IDLE;
      round_r     <= '0;
      dig_r       <= 3'd0;
      eom_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= sha1bh_pkg::H_INIT[i];
      end
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      dig_r       <= dig_nxt;
      eom_r       <= eom_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    for (int i = 0; i < 16; i++) begin
      win_r[i] <= win_nxt[i];
    end
    for (int i = 0; i < 5; i++) begin
      work_r[i] <= work_nxt[i];
    end
  end

endmodule
